/* sv/ring_deque_indexed_defines.svh */
// Assertion macros shared by the ring deque checker.
`ifndef RING_DEQUE_INDEXED_DEFINES_SVH
`define RING_DEQUE_INDEXED_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define RDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring_deque_indexed: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring_deque_indexed: next-cycle check failed");

`endif

/* sv/rdi_pkg.sv */
// Shared types and constants of the ring deque.
`default_nettype none

package rdi_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    // Operation codes
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DROP_BACK  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROP_FRONT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_READ_FRONT = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ_BACK  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd6;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  amount_or_index;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]  fill_level;
    } rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

/* sv/rdi_ctrl.sv */
// Controller state machine of the ring deque: sequences accept, execute, respond.
`default_nettype none

module rdi_ctrl
    import rdi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output logic           done,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance through the three phases of one request
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Drive handshake and datapath commands
    assign busy     = (state_reg != ST_IDLE);
    assign done     = (state_reg == ST_RESP);
    assign cmd.load = (state_reg == ST_IDLE) && start;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

`default_nettype wire

/* sv/rdi_dpath.sv */
// Datapath of the ring deque: pointers, slot store and response registers.
`default_nettype none

module rdi_dpath
    import rdi_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ctrl_cmd_t        cmd,
    input  wire req_t             request,
    input  wire logic [CNT_W-1:0] capacity,
    input  wire logic             cfg_clear,
    output rsp_t                  response
);

    req_t              req_reg;
    logic [PTR_W-1:0]  front_reg;
    logic [PTR_W-1:0]  front_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;
    logic              rd_ok_reg;
    logic              rd_ok_next;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [PTR_W-1:0]  mem_waddr;

    logic              full;
    logic              drop_bad;
    logic              read_bad;
    logic [CNT_W-1:0]  back_idx;
    logic [CNT_W-1:0]  offset;
    logic [CNT_W:0]    sum;
    logic [CNT_W:0]    sum_wrap;
    logic [PTR_W-1:0]  slot;
    logic [PTR_W-1:0]  front_dec;

    // Check the request against the fill level
    assign full     = (count_reg >= capacity);
    assign drop_bad = (req_reg.amount_or_index > count_reg);
    assign read_bad = (req_reg.amount_or_index >= count_reg);
    assign back_idx = count_reg - CNT_W'(1) - req_reg.amount_or_index;

    // Pick the distance from the front for this operation
    always_comb
    begin
        case (req_reg.action)
            ACT_PUSH_BACK: offset = count_reg;
            ACT_READ_BACK: offset = back_idx;
            default:       offset = req_reg.amount_or_index;
        endcase
    end

    // Wrap front plus distance once around the capacity in use
    assign sum       = {2'b00, front_reg} + {1'b0, offset};
    assign sum_wrap  = (sum >= {1'b0, capacity}) ? (sum - {1'b0, capacity}) : sum;
    assign slot      = sum_wrap[PTR_W-1:0];
    assign front_dec = (front_reg == '0) ? PTR_W'(capacity - CNT_W'(1))
                                         : (front_reg - PTR_W'(1));

    // Execute the held request, or empty the queue on a capacity write
    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        mem_we      = 1'b0;
        mem_waddr   = slot;
        if (cfg_clear)
        begin
            front_next = '0;
            count_next = '0;
        end
        else if (cmd.exec)
        begin
            status_next = STAT_OK;
            rd_ok_next  = 1'b0;
            case (req_reg.action)
                ACT_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_PUSH_FRONT:
                begin
                    mem_waddr = front_dec;
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        front_next = front_dec;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_DROP_BACK:
                begin
                    if (drop_bad)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else
                    begin
                        count_next = count_reg - req_reg.amount_or_index;
                    end
                end
                ACT_DROP_FRONT:
                begin
                    if (drop_bad)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else
                    begin
                        front_next = slot;
                        count_next = count_reg - req_reg.amount_or_index;
                    end
                end
                ACT_READ_FRONT, ACT_READ_BACK:
                begin
                    if (read_bad)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                    end
                end
                ACT_CLEAR:
                begin
                    front_next = '0;
                    count_next = '0;
                end
                default:
                begin
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // Hold pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Capture request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= request;
        end
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
    end

    // Slot store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= req_reg.value;
        end
        mem_q_reg <= mem[slot];
    end

    // Drive the response
    assign response.status     = status_reg;
    assign response.read_data  = rd_ok_reg ? mem_q_reg : '0;
    assign response.fill_level = count_reg;

endmodule

`default_nettype wire

/* sv/ring_deque_indexed.sv */
// Done strobes in the respond state, entered from the execute state that
// follows acceptance. A request is taken only in idle, once the previous one
// has run the sequence of accept, execute with registered store read, respond.
// Reset: front and fill level clear, capacity returns to 256, store contents
// stay undefined until written; results cannot be stalled by the receiver.
`default_nettype none

module ring_deque_indexed
    import rdi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        request,
    output logic             done,
    output rsp_t             response,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    ctrl_cmd_t        cmd;
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [CNT_W-1:0] wr_cap;
    logic             cap_sel;
    logic             cfg_wr;

    // Decode the configuration write
    assign pready  = 1'b1;
    assign cap_sel = (paddr[2] == 1'b0);
    assign cfg_wr  = psel && penable && pwrite && cap_sel;

    // Clamp the written capacity into one to DEPTH
    always_comb
    begin
        wr_cap = pwdata[CNT_W-1:0];
        if (wr_cap == '0)
        begin
            wr_cap = CNT_W'(1);
        end
        else if (wr_cap > CNT_W'(DEPTH))
        begin
            wr_cap = CNT_W'(DEPTH);
        end
    end

    assign cap_next = cfg_wr ? wr_cap : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CNT_W'(DEPTH);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    // Return the register on read
    assign prdata = cap_sel ? {{(32-CNT_W){1'b0}}, cap_reg} : 32'd0;

    rdi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rdi_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .request   (request),
        .capacity  (cap_reg),
        .cfg_clear (cfg_wr),
        .response  (response)
    );

endmodule

`default_nettype wire

/* sv/rdi_checker.sv */
// Port-level checker of the ring deque and its bind to the top level.
`default_nettype none
`include "ring_deque_indexed_defines.svh"

module rdi_checker
    import rdi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire logic done,
    input  wire rsp_t response
);

    // An accepted request is answered with done once the respond state is reached
    `RDI_ASSERT_NOW(a_resp_latency, clk, rst_n, start && !busy, ##2 done)
    // Stay busy while the result is shown
    `RDI_ASSERT_NOW(a_done_busy, clk, rst_n, done, busy)
    // Drop the strobe in the cycle after it is raised
    `RDI_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // Only defined codes and a reachable fill level
    `RDI_ASSERT_NOW(a_resp_range, clk, rst_n, done,
        (response.status != 2'd3) && (response.fill_level <= CNT_W'(DEPTH)))

endmodule

bind ring_deque_indexed rdi_checker u_rdi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .response (response)
);

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the ring deque: directed and random requests checked against a mirror.
`default_nettype none

module tb_top;
    import rdi_pkg::*;

    // Register index of the capacity register (byte address 0)
    localparam logic [2:0]       REG_CAPACITY = 3'd0;
    // Action code with no operation behind it
    localparam logic [ACT_W-1:0] ACT_NONE     = 3'd7;
    localparam int               QUIET_LIMIT  = 2000;
    localparam int               REPORT_LIMIT = 50;

    // Mirror of the deque: predicts the response of every accepted request
    class deque_mirror;
        logic [DATA_W-1:0] slots [DEPTH];
        int unsigned       front;
        int unsigned       count;
        int unsigned       cap;
        rsp_t              pending [$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            front   = 0;
            count   = 0;
            cap     = DEPTH;
            errors  = 0;
            checked = 0;
        endfunction

        function int unsigned wrap(int unsigned pos);
            return (pos >= cap) ? pos - cap : pos;
        endfunction

        // Clamp the written value and empty the queue, as a capacity write does
        function void set_capacity(logic [31:0] v);
            int unsigned c;
            c = v & 32'h1FF;
            if (c == 0)
                c = 1;
            if (c > DEPTH)
                c = DEPTH;
            cap   = c;
            front = 0;
            count = 0;
        endfunction

        function void note_request(req_t r);
            rsp_t        want;
            int unsigned amt;
            amt            = r.amount_or_index;
            want.status    = STAT_OK;
            want.read_data = '0;
            case (r.action)
                ACT_PUSH_BACK:
                    if (count >= cap)
                        want.status = STAT_FULL;
                    else
                    begin
                        slots[wrap(front + count)] = r.value;
                        count++;
                    end
                ACT_PUSH_FRONT:
                    if (count >= cap)
                        want.status = STAT_FULL;
                    else
                    begin
                        front        = (front == 0) ? cap - 1 : front - 1;
                        slots[front] = r.value;
                        count++;
                    end
                ACT_DROP_BACK:
                    if (amt > count)
                        want.status = STAT_RANGE;
                    else
                        count -= amt;
                ACT_DROP_FRONT:
                    if (amt > count)
                        want.status = STAT_RANGE;
                    else
                    begin
                        front = wrap(front + amt);
                        count -= amt;
                    end
                ACT_READ_FRONT:
                    if (amt >= count)
                        want.status = STAT_RANGE;
                    else
                        want.read_data = slots[wrap(front + amt)];
                ACT_READ_BACK:
                    if (amt >= count)
                        want.status = STAT_RANGE;
                    else
                        want.read_data = slots[wrap(front + (count - 1 - amt))];
                ACT_CLEAR:
                begin
                    front = 0;
                    count = 0;
                end
                default: ;
            endcase
            want.fill_level = CNT_W'(count);
            pending.push_back(want);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("%0t: %s", $time, msg);
        endfunction

        // Compare a response with the oldest prediction, field by field
        function void check_response(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                fail($sformatf("unexpected response: status %0d data %h fill %0d",
                               got.status, got.read_data, got.fill_level));
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status)
                fail($sformatf("status mismatch: expected %0d actual %0d",
                               want.status, got.status));
            if (got.read_data !== want.read_data)
                fail($sformatf("read_data mismatch: expected %h actual %h",
                               want.read_data, got.read_data));
            if (got.fill_level !== want.fill_level)
                fail($sformatf("fill_level mismatch: expected %0d actual %0d",
                               want.fill_level, got.fill_level));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        request;
    logic        done;
    rsp_t        response;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deque_mirror mirror = new();
    int unsigned idle_pct;
    int unsigned sent;
    int unsigned quiet;
    int unsigned phases;

    ring_deque_indexed uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .response (response),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check responses and watch for a stuck handshake
    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_response(response);
        if ((start && !busy) || done || (psel && penable))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hold a request until accepted; idle at random first
    task automatic issue(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    task automatic op(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val,
                      input int unsigned amt);
        req_t r;
        r.action          = act;
        r.value           = val;
        r.amount_or_index = amt[CNT_W-1:0];
        issue(r);
    endtask

    // Drop start and wait until every predicted response has arrived
    task automatic settle();
        start <= 1'b0;
        while (mirror.pending.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write the capacity register: setup cycle, then access cycle
    task automatic write_capacity(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror.set_capacity(v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed operations in range, with some noise
    function automatic req_t random_request(int unsigned push_pct, int unsigned clear_pct);
        req_t        r;
        int unsigned pick;
        int unsigned held;
        int unsigned amt;
        held  = mirror.count;
        pick  = $urandom_range(99);
        amt   = $urandom_range(511);
        r.value = $urandom;
        if (pick < push_pct)
            r.action = $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
        else if (pick < 100 - clear_pct - 2)
        begin
            case ($urandom_range(3))
                0:       r.action = ACT_DROP_BACK;
                1:       r.action = ACT_DROP_FRONT;
                2:       r.action = ACT_READ_FRONT;
                default: r.action = ACT_READ_BACK;
            endcase
            if (held > 0 && $urandom_range(9) < 8)
            begin
                if (r.action == ACT_READ_FRONT || r.action == ACT_READ_BACK)
                    amt = $urandom_range(held - 1);
                else if ($urandom_range(7) == 0)
                    amt = $urandom_range(held);
                else
                    amt = $urandom_range((held < 3) ? held : 3);
            end
        end
        else if (pick < 98)
            r.action = ACT_CLEAR;
        else
            r.action = ACT_NONE;
        r.amount_or_index = amt[CNT_W-1:0];
        return r;
    endfunction

    task automatic run_phase(input logic [31:0] cap_value, input int unsigned n,
                             input int unsigned push_pct, input int unsigned clear_pct,
                             input int unsigned idle);
        write_capacity(cap_value);
        idle_pct = idle;
        repeat (n) issue(random_request(push_pct, clear_pct));
        settle();
        phases++;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        idle_pct = 0;
        sent     = 0;
        phases   = 0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset capacity, empty reads, wrap of the front both ways
        op(ACT_READ_FRONT, 32'h0, 0);
        op(ACT_DROP_BACK, 32'h0, 0);
        op(ACT_DROP_FRONT, 32'h0, 1);
        op(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 0);
        op(ACT_PUSH_BACK, 32'h0, 0);
        op(ACT_PUSH_BACK, 32'hA5A5_5A5A, 0);
        op(ACT_READ_FRONT, 32'h0, 0);
        op(ACT_READ_FRONT, 32'h0, 2);
        op(ACT_READ_BACK, 32'h0, 0);
        op(ACT_READ_BACK, 32'h0, 2);
        op(ACT_READ_FRONT, 32'h0, 3);
        op(ACT_READ_BACK, 32'h0, 256);
        op(ACT_DROP_FRONT, 32'h0, 256);
        op(ACT_DROP_FRONT, 32'h0, 1);
        op(ACT_DROP_BACK, 32'h0, 1);
        op(ACT_NONE, 32'h1234_5678, 511);
        op(ACT_READ_FRONT, 32'h0, 0);
        op(ACT_CLEAR, 32'h0, 0);
        op(ACT_READ_BACK, 32'h0, 0);
        settle();

        // Directed: tiny ring, pushes into a full queue, drop past the fill level
        write_capacity(32'd2);
        op(ACT_PUSH_BACK, 32'h0000_0001, 0);
        op(ACT_PUSH_FRONT, 32'h0000_0002, 0);
        op(ACT_PUSH_BACK, 32'h0000_0003, 0);
        op(ACT_PUSH_FRONT, 32'h0000_0004, 0);
        op(ACT_READ_BACK, 32'h0, 0);
        op(ACT_READ_FRONT, 32'h0, 1);
        op(ACT_DROP_BACK, 32'h0, 2);
        op(ACT_DROP_BACK, 32'h0, 1);
        settle();

        // Random phases over capacities, extremes and clamped values included
        run_phase(32'd511, 250, 85, 0, 0);
        run_phase(32'd1, 80, 45, 3, 86);
        run_phase(32'd0, 40, 45, 3, 0);
        run_phase(32'd3, 80, 45, 3, 19);
        run_phase(32'd17, 100, 50, 2, 86);
        run_phase(32'd256, 80, 50, 2, 0);
        run_phase(32'd2, 60, 45, 3, 19);
        run_phase($urandom_range(256, 1), 80, 50, 2, 86);

        $display("Sent %0d requests, checked %0d responses over %0d capacity phases.",
                 sent, mirror.checked, phases);
        $display("Mismatches: %0d", mirror.errors);
        if (mirror.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
